### rtl/core/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// Slot table sizing, operation and status codes, payload structs.
// ----------------------------------------------------------------------------
package ptts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = IDX_W + 1;

	localparam int FIRE_W    = 16;
	localparam int SLOT_W    = 4;
	localparam int TS_W      = 32;
	localparam int ID_W      = 64;
	localparam int ARG_W     = 64;
	localparam int KEY_W     = ID_W + ARG_W;
	localparam int PERIOD_W  = 32;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_RUN    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;

	typedef struct packed {
		logic [1:0]                 operation;
		logic signed [TS_W-1:0]     tick_increment;
		logic [ID_W-1:0]            handler_id;
		logic [ARG_W-1:0]           handler_arg;
		logic [PERIOD_W-1:0]        task_period;
	} sched_in_t;

	typedef struct packed {
		logic [FIRE_W-1:0] fire_mask;
		logic [SLOT_W-1:0] slot_index;
		logic [1:0]        status;
		logic [TS_W-1:0]   timestamp;
	} sched_out_t;

endpackage

### rtl/core/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: table of periodic task slots
// Items are taken only while idle; each operation walks all slots once through
// the single read port of the slot RAMs, and no new item is taken until the
// result has been loaded into the output register.
// A finished result waiting in the output register stalls only the last step.
// Reset: asynchronous; all slots invalid, clock at zero; slot RAMs not cleared.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ptts_pkg::sched_in_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ptts_pkg::sched_out_t  out_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]                      state_q;
	logic [ptts_pkg::CNT_W-1:0]      issue_q;
	logic                            vld_s1;
	logic [ptts_pkg::IDX_W-1:0]      idx_s1;
	logic [ptts_pkg::MAX_TASKS-1:0]  valid_q;
	logic                            found_q;
	logic [ptts_pkg::IDX_W-1:0]      hit_idx_q;
	logic [ptts_pkg::FIRE_W-1:0]     mask_q;
	logic [ptts_pkg::TS_W-1:0]       ts_q;
	logic                            out_valid_q;
	ptts_pkg::sched_out_t            out_q;

	logic [1:0]                      op_q;
	logic [ptts_pkg::KEY_W-1:0]      key_q;
	logic [ptts_pkg::PERIOD_W-1:0]   period_q;

	logic [ptts_pkg::KEY_W-1:0]      key_rd;
	logic [ptts_pkg::PERIOD_W-1:0]   per_rd;
	logic [ptts_pkg::PERIOD_W-1:0]   cnt_rd;
	logic [ptts_pkg::PERIOD_W-1:0]   dec;
	logic [ptts_pkg::PERIOD_W-1:0]   cnt_wd;
	logic                            cnt_we;
	logic                            key_we;
	logic                            hit;
	logic                            fire;
	logic                            slot_v;
	logic                            key_hit;
	logic                            accept;
	logic                            issuing;
	logic                            can_load;
	logic [ptts_pkg::IDX_W-1:0]      rd_addr;
	logic [1:0]                      fin_status;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign issuing  = (state_q == S_WALK) &&
	                  (issue_q != ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS));
	assign rd_addr  = issue_q[ptts_pkg::IDX_W-1:0];
	assign can_load = !out_valid_q || out_ready;

	ptts_ram #(.WIDTH(ptts_pkg::KEY_W), .DEPTH(ptts_pkg::MAX_TASKS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (idx_s1),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	ptts_ram #(.WIDTH(ptts_pkg::PERIOD_W), .DEPTH(ptts_pkg::MAX_TASKS)) u_per_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (idx_s1),
		.wdata (period_q),
		.raddr (rd_addr),
		.rdata (per_rd)
	);

	ptts_ram #(.WIDTH(ptts_pkg::PERIOD_W), .DEPTH(ptts_pkg::MAX_TASKS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (idx_s1),
		.wdata (cnt_wd),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);

	// Per-slot step of the walk: one decrement, one key compare
	always_comb begin
		dec     = cnt_rd - ptts_pkg::PERIOD_W'(1);
		slot_v  = valid_q[idx_s1];
		key_hit = slot_v && (key_rd == key_q);
		cnt_we  = 1'b0;
		cnt_wd  = dec;
		key_we  = 1'b0;
		hit     = 1'b0;
		fire    = 1'b0;
		if (vld_s1 && !found_q) begin
			case (op_q)
				ptts_pkg::OP_TICK: begin
					if (slot_v) begin
						cnt_we = 1'b1;
						if (dec == '0) begin
							cnt_wd = per_rd;
							fire   = 1'b1;
						end
					end
				end
				ptts_pkg::OP_ADD: begin
					if (!slot_v) begin
						cnt_we = 1'b1;
						cnt_wd = ptts_pkg::PERIOD_W'(1);
						key_we = 1'b1;
						hit    = 1'b1;
					end
				end
				ptts_pkg::OP_REMOVE: begin
					hit = key_hit;
				end
				ptts_pkg::OP_RUN: begin
					if (key_hit) begin
						hit    = 1'b1;
						fire   = 1'b1;
						cnt_we = 1'b1;
						cnt_wd = per_rd;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		fin_status = ptts_pkg::ST_OK;
		if (!found_q && op_q == ptts_pkg::OP_ADD) begin
			fin_status = ptts_pkg::ST_NO_SPACE;
		end else if (!found_q && op_q == ptts_pkg::OP_REMOVE) begin
			fin_status = ptts_pkg::ST_NO_MATCH;
		end
	end

	// Item payload, held for the whole walk
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_data.operation;
			key_q    <= {in_data.handler_id, in_data.handler_arg};
			period_q <= in_data.task_period;
		end
		if (state_q == S_FIN && can_load) begin
			out_q.fire_mask  <= mask_q;
			out_q.slot_index <= ptts_pkg::SLOT_W'(hit_idx_q);
			out_q.status     <= fin_status;
			out_q.timestamp  <= ts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			hit_idx_q   <= '0;
			mask_q      <= '0;
			ts_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken result unless a new one is loaded in its place
			if (out_valid_q && out_ready && !(state_q == S_FIN && can_load)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.operation == ptts_pkg::OP_TICK &&
						    in_data.tick_increment > 32'sd0) begin
							ts_q <= ts_q + unsigned'(in_data.tick_increment);
						end
						issue_q   <= '0;
						vld_s1    <= 1'b0;
						found_q   <= 1'b0;
						hit_idx_q <= '0;
						mask_q    <= '0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					vld_s1 <= issuing;
					if (issuing) begin
						idx_s1  <= rd_addr;
						issue_q <= issue_q + ptts_pkg::CNT_W'(1);
					end else if (!vld_s1) begin
						state_q <= S_FIN;
					end
					if (hit) begin
						found_q   <= 1'b1;
						hit_idx_q <= idx_s1;
						if (op_q == ptts_pkg::OP_ADD) begin
							valid_q[idx_s1] <= 1'b1;
						end else if (op_q == ptts_pkg::OP_REMOVE) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
					// only slots inside the output width show up in the mask
					for (int j = 0; j < ptts_pkg::FIRE_W; j++) begin
						if (fire && ptts_pkg::CNT_W'(idx_s1) == ptts_pkg::CNT_W'(j)) begin
							mask_q[j] <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/ptts_ram.sv
// ----------------------------------------------------------------------------
// ptts_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker: port-level checks of the periodic task tick scheduler
// Watches the item handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module ptts_port_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input ptts_pkg::sched_in_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input ptts_pkg::sched_out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item at a time: busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while a walk is running");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ptts_pkg::ST_OK ||
		               out_data.status == ptts_pkg::ST_NO_SPACE ||
		               out_data.status == ptts_pkg::ST_NO_MATCH))
		else $error("unknown status code");

	// a failed add or remove fires nothing and names slot zero
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ptts_pkg::ST_OK |->
			out_data.fire_mask == '0 && out_data.slot_index == '0)
		else $error("failed item shows fired slots or an index");

	// a new result shows as the block turns ready for the next item
	a_no_accept_with_mask: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while still busy");

endmodule

bind periodic_task_tick_scheduler ptts_port_checker u_ptts_checker (.*);
